FILE: hw/rtl/cjd_pkg.sv
package cjd_pkg;

	// register ranks of the shared datapath, from input capture to final datapath rank
	localparam int DP_DEPTH = 16;
	// ranks used by the civil to day number path before padding
	localparam int TO_JD_DEPTH = 5;

	localparam logic signed [23:0] YEAR_MAX = 24'sd5874773;
	localparam logic signed [23:0] YEAR_MIN = -24'sd5877752;
	localparam logic [3:0] MONTH_MAX = 4'd8;
	localparam logic [4:0] DAY_MAX = 5'd15;
	localparam logic [3:0] MONTH_MIN = 4'd5;
	localparam logic [4:0] DAY_MIN = 5'd8;
	localparam logic signed [31:0] JD_MAX = 32'sd2147438064;
	localparam logic signed [31:0] JD_MIN = -32'sd2145083647;

	typedef enum logic {
		CMD_TO_JD    = 1'b0,
		CMD_TO_CIVIL = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t               command;
		logic signed [23:0] civil_year;
		logic [3:0]         civil_month;
		logic [4:0]         civil_day;
		logic signed [31:0] day_number;
	} req_t;

	typedef struct packed {
		logic signed [31:0] julian_day;
		logic signed [23:0] out_year;
		logic [3:0]         out_month;
		logic [4:0]         out_day;
		logic               range_error;
	} rsp_t;

	// floor(30.6001 * mm)
	function automatic logic [8:0] month_term(input logic [4:0] mm);
		logic [8:0] t;
		case (mm)
			5'd0:    t = 9'd0;
			5'd1:    t = 9'd30;
			5'd2:    t = 9'd61;
			5'd3:    t = 9'd91;
			5'd4:    t = 9'd122;
			5'd5:    t = 9'd153;
			5'd6:    t = 9'd183;
			5'd7:    t = 9'd214;
			5'd8:    t = 9'd244;
			5'd9:    t = 9'd275;
			5'd10:   t = 9'd306;
			5'd11:   t = 9'd336;
			5'd12:   t = 9'd367;
			5'd13:   t = 9'd397;
			5'd14:   t = 9'd428;
			5'd15:   t = 9'd459;
			5'd16:   t = 9'd489;
			default: t = 9'd0;
		endcase
		return t;
	endfunction

endpackage

FILE: hw/rtl/cjd_cdiv.sv
// unsigned divide by a constant, three register ranks:
// truncated reciprocal estimate (low by at most one), back-multiply, one correction step
module cjd_cdiv #(
	parameter int NUM_W = 24,
	parameter int DIVISOR = 100,
	parameter int QUO_W = 17
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	output logic [QUO_W-1:0] quo
);

	localparam int SH = $clog2(DIVISOR) - 2;
	localparam int HW = NUM_W - SH;
	localparam int QN = HW - 1;
	localparam int DW = SH + 2;
	localparam logic [HW-1:0] RECIP = HW'((64'd1 << (NUM_W + 1)) / DIVISOR);

	logic [2*HW-1:0]  prod_s1;
	logic [NUM_W-1:0] num_s1;
	logic [QN-1:0]    q0_s2;
	logic [NUM_W-1:0] back_s2;
	logic [NUM_W-1:0] num_s2;
	logic [QN+DW-1:0] back_full;
	logic [NUM_W:0]   rem;
	logic [QN-1:0]    q_fix;

	assign back_full = (QN+DW)'(prod_s1[2*HW-1:HW+1]) * (QN+DW)'(DIVISOR);
	assign rem = {1'b0, num_s2} - {1'b0, back_s2};
	assign q_fix = q0_s2 + QN'(rem >= (NUM_W+1)'(DIVISOR));

	always_ff @(posedge clk) begin
		prod_s1 <= (2*HW)'(num[NUM_W-1:SH]) * (2*HW)'(RECIP);
		num_s1 <= num;
		q0_s2 <= prod_s1[2*HW-1:HW+1];
		back_s2 <= back_full[NUM_W-1:0];
		num_s2 <= num_s1;
		quo <= q_fix[QUO_W-1:0];
	end

endmodule

FILE: hw/rtl/cjd_to_jd.sv
module cjd_to_jd import cjd_pkg::*; (
	input  logic               clk,
	input  logic signed [23:0] year,
	input  logic [3:0]         month,
	input  logic [4:0]         day,
	output logic signed [31:0] jd
);

	localparam int PAD = DP_DEPTH - TO_JD_DEPTH;

	logic               early;
	logic [4:0]         mm;
	logic signed [24:0] va_full;
	logic [23:0]        va_s1;
	logic signed [24:0] yy_s1;
	logic [8:0]         mterm_s1;
	logic [4:0]         day_s1;
	logic signed [35:0] yt_s2;
	logic [8:0]         mterm_s2;
	logic [4:0]         day_s2;
	logic signed [35:0] base_s3;
	logic signed [35:0] base_s4;
	logic [16:0]        aq;
	logic signed [35:0] jd_full;
	logic [31:0]        jd_s5;
	logic [31:0]        jd_pad_q [PAD];

	// january and february count as months 13 and 14 of the year before
	assign early = (month <= 4'd2);
	assign mm = early ? 5'(month) + 5'd13 : 5'(month) + 5'd1;
	// century term divides a biased, non-negative year
	assign va_full = 25'(year) + (early ? 25'sd5999999 : 25'sd6000000);

	cjd_cdiv #(
		.NUM_W(24),
		.DIVISOR(100),
		.QUO_W(17)
	) u_div_a (
		.clk(clk),
		.num(va_s1),
		.quo(aq)
	);

	// 2 - a + floor(a/4) with a = aq - 60000
	assign jd_full = base_s4 + 36'(aq >> 2) - 36'(aq) + 36'sd45000;

	always_ff @(posedge clk) begin
		va_s1 <= va_full[23:0];
		yy_s1 <= 25'(year) + (early ? 25'sd4715 : 25'sd4716);
		mterm_s1 <= month_term(mm);
		day_s1 <= day;
		yt_s2 <= (36'(yy_s1) * 36'sd1461) >>> 2;
		mterm_s2 <= mterm_s1;
		day_s2 <= day_s1;
		base_s3 <= yt_s2 + 36'(mterm_s2) + 36'(day_s2) - 36'sd1522;
		base_s4 <= base_s3;
		jd_s5 <= jd_full[31:0];
		jd_pad_q[0] <= jd_s5;
		for (int i = 1; i < PAD; i++) begin
			jd_pad_q[i] <= jd_pad_q[i-1];
		end
	end

	assign jd = jd_pad_q[PAD-1];

endmodule

FILE: hw/rtl/cjd_from_jd.sv
module cjd_from_jd import cjd_pkg::*; (
	input  logic               clk,
	input  logic signed [31:0] jd,
	output logic signed [23:0] year,
	output logic [3:0]         month,
	output logic [4:0]         day
);

	logic signed [35:0] vx_full;
	logic [34:0]        vx_s1;
	logic signed [31:0] jd_s1, jd_s2, jd_s3, jd_s4;
	logic [16:0]        xq;
	logic signed [33:0] b_s5, b_s6, b_s7, b_s8, b_s9, b_s10;
	logic signed [37:0] vc_full;
	logic [36:0]        vc_s6;
	logic [23:0]        cq;
	logic signed [35:0] dd_full;
	logic signed [35:0] dd_s10;
	logic signed [25:0] c_s10, c_s11, c_s12, c_s13, c_s14, c_s15;
	logic signed [35:0] diff_full;
	logic [8:0]         diff_s11, diff_s12, diff_s13, diff_s14, diff_s15;
	logic [22:0]        ve_s12;
	logic [3:0]         eq;
	logic [8:0]         day_full;
	logic signed [25:0] year_full;

	// 4*jd - 7468865, biased by 60000 periods of 146097
	assign vx_full = (36'(jd) <<< 2) + 36'sd8758351135;

	cjd_cdiv #(
		.NUM_W(35),
		.DIVISOR(146097),
		.QUO_W(17)
	) u_div_x (
		.clk(clk),
		.num(vx_s1),
		.quo(xq)
	);

	// 20*b - 2442, biased by 6000000 periods of 7305
	assign vc_full = (38'(b_s5) <<< 4) + (38'(b_s5) <<< 2) + 38'sd43829997558;

	cjd_cdiv #(
		.NUM_W(37),
		.DIVISOR(7305),
		.QUO_W(24)
	) u_div_c (
		.clk(clk),
		.num(vc_s6),
		.quo(cq)
	);

	assign dd_full = $signed(36'(cq) * 36'd1461) - 36'sd8766000000;
	// day within the shifted year, always small and positive
	assign diff_full = 36'(b_s10) - dd_s10;

	cjd_cdiv #(
		.NUM_W(23),
		.DIVISOR(306001),
		.QUO_W(4)
	) u_div_e (
		.clk(clk),
		.num(ve_s12),
		.quo(eq)
	);

	assign day_full = diff_s15 - month_term(5'(eq));
	assign year_full = c_s15 - ((eq <= 4'd13) ? 26'sd4716 : 26'sd4715);

	always_ff @(posedge clk) begin
		vx_s1 <= vx_full[34:0];
		jd_s1 <= jd;
		jd_s2 <= jd_s1;
		jd_s3 <= jd_s2;
		jd_s4 <= jd_s3;
		// jd + 1 + x - floor(x/4) + 1524 with x = xq - 60000
		b_s5 <= 34'(jd_s4) + 34'(xq) - 34'(xq >> 2) - 34'sd43475;
		vc_s6 <= vc_full[36:0];
		b_s6 <= b_s5;
		b_s7 <= b_s6;
		b_s8 <= b_s7;
		b_s9 <= b_s8;
		b_s10 <= b_s9;
		c_s10 <= 26'(cq) - 26'sd6000000;
		dd_s10 <= dd_full >>> 2;
		diff_s11 <= diff_full[8:0];
		c_s11 <= c_s10;
		ve_s12 <= 23'(diff_s11) * 23'd10000;
		diff_s12 <= diff_s11;
		c_s12 <= c_s11;
		diff_s13 <= diff_s12;
		diff_s14 <= diff_s13;
		diff_s15 <= diff_s14;
		c_s13 <= c_s12;
		c_s14 <= c_s13;
		c_s15 <= c_s14;
		day <= day_full[4:0];
		month <= (eq <= 4'd13) ? eq - 4'd1 : eq - 4'd13;
		year <= year_full[23:0];
	end

endmodule

FILE: hw/rtl/civil_julian_day_converter.sv
// Civil date / Julian Day Number converter, proleptic Gregorian calendar.
// A request beat is taken on every rising edge where start is high; busy is
// never raised, so a new request may follow in every cycle. request.command
// picks the direction: civil year/month/day to day number, or day number
// back to year/month/day. The fields of the other direction are ignored.
// Each request gives exactly one result beat: done is high for one cycle
// with result valid in that same cycle. The request passes 16 datapath
// ranks and then the output register, the first rank loading at the
// accepting edge. Sustained rate is one beat per cycle; latency is set by
// the three reciprocal-multiply dividers of the day number path, three
// ranks each, in series with their setup ranks.
// Dates past the supported limits return all fields zero with range_error.
// Reset clears only the valid line and done; requests in flight are dropped.
// The receiver cannot stall, so results leave in request order, one per beat.
module civil_julian_day_converter import cjd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output rsp_t result
);

	logic                accept;
	logic                in_err;
	logic                civil_err;
	logic                jd_err;
	logic [DP_DEPTH-1:0] vld_line_q;
	logic [DP_DEPTH-1:0] cmd_line_q;
	logic [DP_DEPTH-1:0] err_line_q;
	logic signed [31:0]  jd_dp;
	logic signed [23:0]  year_dp;
	logic [3:0]          month_dp;
	logic [4:0]          day_dp;
	rsp_t                rsp_next;
	rsp_t                result_s17;
	logic                done_s17;

	assign busy = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		civil_err = (request.civil_year > YEAR_MAX) || (request.civil_year < YEAR_MIN);
		if (request.civil_year == YEAR_MAX) begin
			civil_err = (request.civil_month > MONTH_MAX) ||
				((request.civil_month == MONTH_MAX) && (request.civil_day > DAY_MAX));
		end else if (request.civil_year == YEAR_MIN) begin
			civil_err = (request.civil_month < MONTH_MIN) ||
				((request.civil_month == MONTH_MIN) && (request.civil_day < DAY_MIN));
		end
		jd_err = (request.day_number > JD_MAX) || (request.day_number < JD_MIN);
		in_err = (request.command == CMD_TO_JD) ? civil_err : jd_err;
	end

	cjd_to_jd u_to_jd (
		.clk(clk),
		.year(request.civil_year),
		.month(request.civil_month),
		.day(request.civil_day),
		.jd(jd_dp)
	);

	cjd_from_jd u_from_jd (
		.clk(clk),
		.jd(request.day_number),
		.year(year_dp),
		.month(month_dp),
		.day(day_dp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_line_q <= '0;
			done_s17 <= 1'b0;
		end else begin
			vld_line_q <= {vld_line_q[DP_DEPTH-2:0], accept};
			done_s17 <= vld_line_q[DP_DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		cmd_line_q <= {cmd_line_q[DP_DEPTH-2:0], request.command};
		err_line_q <= {err_line_q[DP_DEPTH-2:0], in_err};
		result_s17 <= rsp_next;
	end

	// both directions run on every beat; range error, else command, picks one
	always_comb begin
		rsp_next = '0;
		if (err_line_q[DP_DEPTH-1]) begin
			rsp_next.range_error = 1'b1;
		end else if (cmd_line_q[DP_DEPTH-1] == CMD_TO_JD) begin
			rsp_next.julian_day = jd_dp;
		end else begin
			rsp_next.out_year = year_dp;
			rsp_next.out_month = month_dp;
			rsp_next.out_day = day_dp;
		end
	end

	assign done = done_s17;
	assign result = result_s17;

endmodule
